[rtl/mfsgd_pkg.sv]
`timescale 1ns / 1ps

package mfsgd_pkg;

	// table geometry
	localparam int ROW_AW  = 12;
	localparam int COL_AW  = 12;
	localparam int FAC_AW  = 5;
	localparam int FACT_W  = 6;
	localparam int RFA_AW  = ROW_AW + FAC_AW;
	localparam int CFA_AW  = COL_AW + FAC_AW;
	localparam logic [FACT_W-1:0] FACTORS = 6'd32;

	// opcodes
	localparam logic [2:0] OP_WR_ROW = 3'd0;
	localparam logic [2:0] OP_WR_COL = 3'd1;
	localparam logic [2:0] OP_RD_ROW = 3'd2;
	localparam logic [2:0] OP_RD_COL = 3'd3;
	localparam logic [2:0] OP_TRAIN  = 3'd4;
	localparam logic [2:0] OP_EVAL   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_LR   = 3'd0;
	localparam logic [2:0] CFG_BD   = 3'd1;
	localparam logic [2:0] CFG_FD   = 3'd2;
	localparam logic [2:0] CFG_GM   = 3'd3;
	localparam logic [2:0] CFG_AF   = 3'd4;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [11:0]        row_index;
		logic [11:0]        col_index;
		logic [5:0]         slot;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic signed [31:0] residual;
		logic signed [31:0] read_data;
		logic               saturated;
	} out_t;

	// request to the shared multiplier
	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
	} mul_req_t;

	// clip to signed 32 bits; top bit is the clip flag
	function automatic logic [32:0] sat32(input logic signed [47:0] x);
		logic [32:0] r;
		if (x > 48'sd2147483647)
			r = {1'b1, 32'h7fff_ffff};
		else if (x < -48'sd2147483648)
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, x[31:0]};
		return r;
	endfunction

endpackage

[rtl/mfsgd_ram.sv]
`timescale 1ns / 1ps

// single-address RAM, read data registered (read before write)
module mfsgd_ram #(
	parameter int AW = 12,
	parameter int W  = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

[rtl/mfsgd_mul.sv]
`timescale 1ns / 1ps

// shared signed multiplier, product registered
module mfsgd_mul (
	input  logic                clk,
	input  mfsgd_pkg::mul_req_t req,
	output logic signed [65:0]  p
);

	logic signed [65:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= req.a * req.b;
	end

	assign p = p_q;

endmodule

[rtl/biased_mf_sgd_update.sv]
`timescale 1ns / 1ps

// channel | dir | handshake           | payload
// in      | in  | in_valid / in_stall  | in_item  (mfsgd_pkg::in_t)
// out     | out | out_valid / out_stall| out_item (mfsgd_pkg::out_t)
// cfg     | in  | cfg_we               | cfg_idx, cfg_wdata
//
// Writes finish after the issue step, reads after a data step, evaluate after the dot pass
// over nf factors (nf = active factors, clipped to 32) and train after a further update pass.
// One registered multiplier does all products: one per factor in the dot pass, and in the
// update pass four per factor entry and three per bias entry.
// Reset clears control and loads configuration defaults only; tables are not initialized.
// in_stall is high while an item is at work; a stalled result waits in the output register.
module biased_mf_sgd_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mfsgd_pkg::in_t     in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output mfsgd_pkg::out_t    out_item,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_ISSUE, S_RDATA, S_BIAS, S_DOT_MUL, S_DOT_ACC, S_RES,
		S_FWAIT, S_FLOAD, U_G, U_D, U_I, U_L, U_W, S_DONE
	} state_t;

	typedef enum logic [1:0] {TG_RB, TG_CB, TG_U, TG_V} tgt_t;

	state_t state_q;
	tgt_t   tgt_q;

	// configuration
	logic [23:0]        lr_q, bd_q, fd_q;
	logic signed [31:0] gm_q;
	logic [5:0]         af_q;
	logic [5:0]         nf;

	// item and working registers
	logic [2:0]         op_q;
	logic [11:0]        r_q, c_q;
	logic [5:0]         slot_q, k_q;
	logic signed [31:0] val_q, res_q, rd_q;
	logic               flag_q;
	logic signed [47:0] acc_q;
	logic signed [31:0] rb_q, cb_q, u_q, v_q;
	logic signed [63:0] g_q;
	logic [23:0]        flo_q;
	logic signed [41:0] ph_q;
	logic               out_valid_q;
	mfsgd_pkg::out_t    out_q;

	// memory ports
	logic               rb_we, cb_we, uf_we, vf_we;
	logic [31:0]        wdata;
	logic signed [31:0] rb_rd, cb_rd, uf_rd, vf_rd;
	logic [mfsgd_pkg::RFA_AW-1:0] uf_addr;
	logic [mfsgd_pkg::CFA_AW-1:0] vf_addr;

	// arithmetic
	mfsgd_pkg::mul_req_t mreq;
	logic signed [65:0]  p;
	logic signed [31:0]  old_v, partner;
	logic [23:0]         decay;
	logic signed [64:0]  inner;
	logic signed [40:0]  fcomb;
	logic signed [43:0]  delta, newv;
	logic [32:0]         sat_w, sat_r;
	logic                in_fire;
	logic                is_rd;

	assign nf       = (af_q > mfsgd_pkg::FACTORS) ? mfsgd_pkg::FACTORS : af_q;
	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && (state_q == S_IDLE);
	assign is_rd    = (op_q == mfsgd_pkg::OP_RD_ROW) || (op_q == mfsgd_pkg::OP_RD_COL);

	// operand selection for the entry being updated
	always_comb begin
		case (tgt_q)
			TG_RB: old_v = rb_q;
			TG_CB: old_v = cb_q;
			TG_U:  old_v = u_q;
			default: old_v = v_q;
		endcase
		partner = (tgt_q == TG_U) ? v_q : u_q;
		decay   = (tgt_q == TG_RB || tgt_q == TG_CB) ? bd_q : fd_q;
	end

	// update arithmetic on the product of the previous cycle
	assign inner = {g_q[63], g_q} - {p[63], p[63:0]};
	assign fcomb = inner[64:24];
	assign delta = {{2{ph_q[41]}}, ph_q} + {19'd0, p[48:24]};
	assign newv  = {{12{old_v[31]}}, old_v} + delta;
	assign sat_w = mfsgd_pkg::sat32({{4{newv[43]}}, newv});
	assign sat_r = mfsgd_pkg::sat32(acc_q);

	// multiplier operands per step
	always_comb begin
		mreq = '0;
		case (state_q)
			S_DOT_MUL: begin
				mreq.a = {uf_rd[31], uf_rd};
				mreq.b = {vf_rd[31], vf_rd};
			end
			U_G: begin
				mreq.a = {res_q[31], res_q};
				mreq.b = {partner[31], partner};
			end
			U_D: begin
				mreq.a = {9'd0, decay};
				mreq.b = {old_v[31], old_v};
			end
			U_I: begin
				mreq.a = {9'd0, lr_q};
				mreq.b = {{16{fcomb[40]}}, fcomb[40:24]};
			end
			U_L: begin
				mreq.a = {9'd0, lr_q};
				mreq.b = {9'd0, fcomb[23:0] & 24'd0 | flo_q};
			end
			default: mreq = '0;
		endcase
	end

	// table write strobes
	always_comb begin
		rb_we = 1'b0;
		cb_we = 1'b0;
		uf_we = 1'b0;
		vf_we = 1'b0;
		if (state_q == S_ISSUE) begin
			rb_we = (op_q == mfsgd_pkg::OP_WR_ROW) && (slot_q == mfsgd_pkg::FACTORS);
			uf_we = (op_q == mfsgd_pkg::OP_WR_ROW) && (slot_q < mfsgd_pkg::FACTORS);
			cb_we = (op_q == mfsgd_pkg::OP_WR_COL) && (slot_q == mfsgd_pkg::FACTORS);
			vf_we = (op_q == mfsgd_pkg::OP_WR_COL) && (slot_q < mfsgd_pkg::FACTORS);
		end else if (state_q == U_W) begin
			rb_we = (tgt_q == TG_RB);
			cb_we = (tgt_q == TG_CB);
			uf_we = (tgt_q == TG_U);
			vf_we = (tgt_q == TG_V);
		end
	end

	assign wdata   = (state_q == S_ISSUE) ? val_q : sat_w[31:0];
	assign uf_addr = {r_q, k_q[mfsgd_pkg::FAC_AW-1:0]};
	assign vf_addr = {c_q, k_q[mfsgd_pkg::FAC_AW-1:0]};

	mfsgd_ram #(.AW(mfsgd_pkg::ROW_AW), .W(32)) u_rb (
		.clk(clk), .we(rb_we), .addr(r_q), .wdata(wdata), .rdata(rb_rd)
	);
	mfsgd_ram #(.AW(mfsgd_pkg::COL_AW), .W(32)) u_cb (
		.clk(clk), .we(cb_we), .addr(c_q), .wdata(wdata), .rdata(cb_rd)
	);
	mfsgd_ram #(.AW(mfsgd_pkg::RFA_AW), .W(32)) u_uf (
		.clk(clk), .we(uf_we), .addr(uf_addr), .wdata(wdata), .rdata(uf_rd)
	);
	mfsgd_ram #(.AW(mfsgd_pkg::CFA_AW), .W(32)) u_vf (
		.clk(clk), .we(vf_we), .addr(vf_addr), .wdata(wdata), .rdata(vf_rd)
	);

	mfsgd_mul u_mul (
		.clk(clk), .req(mreq), .p(p)
	);

	// sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tgt_q       <= TG_RB;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			lr_q        <= 24'd16777;
			bd_q        <= 24'd167772;
			fd_q        <= 24'd167772;
			gm_q        <= '0;
			af_q        <= 6'd32;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					mfsgd_pkg::CFG_LR: lr_q <= cfg_wdata[23:0];
					mfsgd_pkg::CFG_BD: bd_q <= cfg_wdata[23:0];
					mfsgd_pkg::CFG_FD: fd_q <= cfg_wdata[23:0];
					mfsgd_pkg::CFG_GM: gm_q <= cfg_wdata;
					mfsgd_pkg::CFG_AF: af_q <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						k_q     <= (in_item.opcode <= mfsgd_pkg::OP_RD_COL) ? in_item.slot : 6'd0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (is_rd)
						state_q <= S_RDATA;
					else if (op_q == mfsgd_pkg::OP_TRAIN || op_q == mfsgd_pkg::OP_EVAL)
						state_q <= S_BIAS;
					else
						state_q <= S_DONE;
				end
				S_RDATA: state_q <= S_DONE;
				S_BIAS: begin
					k_q     <= '0;
					state_q <= (nf == 6'd0) ? S_RES : S_DOT_MUL;
				end
				S_DOT_MUL: begin
					k_q     <= k_q + 6'd1;
					state_q <= S_DOT_ACC;
				end
				S_DOT_ACC: state_q <= (k_q == nf) ? S_RES : S_DOT_MUL;
				S_RES: begin
					k_q   <= '0;
					tgt_q <= TG_RB;
					state_q <= (op_q == mfsgd_pkg::OP_TRAIN) ? U_D : S_DONE;
				end
				S_FWAIT: state_q <= S_FLOAD;
				S_FLOAD: begin
					tgt_q   <= TG_U;
					state_q <= U_G;
				end
				U_G: state_q <= U_D;
				U_D: state_q <= U_I;
				U_I: state_q <= U_L;
				U_L: state_q <= U_W;
				U_W: begin
					case (tgt_q)
						TG_RB: begin
							tgt_q   <= TG_CB;
							state_q <= U_D;
						end
						TG_CB: state_q <= (nf == 6'd0) ? S_DONE : S_FWAIT;
						TG_U: begin
							tgt_q   <= TG_V;
							state_q <= U_G;
						end
						default: begin
							if ((k_q + 6'd1) == nf) begin
								state_q <= S_DONE;
							end else begin
								k_q     <= k_q + 6'd1;
								state_q <= S_FWAIT;
							end
						end
					endcase
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q   <= in_item.opcode;
					r_q    <= in_item.row_index;
					c_q    <= in_item.col_index;
					slot_q <= in_item.slot;
					val_q  <= in_item.value;
					res_q  <= '0;
					rd_q   <= '0;
					flag_q <= 1'b0;
				end
			end
			S_RDATA: begin
				if (slot_q == mfsgd_pkg::FACTORS)
					rd_q <= (op_q == mfsgd_pkg::OP_RD_ROW) ? rb_rd : cb_rd;
				else if (slot_q < mfsgd_pkg::FACTORS)
					rd_q <= (op_q == mfsgd_pkg::OP_RD_ROW) ? uf_rd : vf_rd;
				else
					rd_q <= '0;
			end
			S_BIAS: begin
				acc_q <= {{16{val_q[31]}}, val_q} - {{16{gm_q[31]}}, gm_q}
					- {{16{rb_rd[31]}}, rb_rd} - {{16{cb_rd[31]}}, cb_rd};
				rb_q  <= rb_rd;
				cb_q  <= cb_rd;
			end
			S_DOT_ACC: acc_q <= acc_q - {{6{p[65]}}, p[65:24]};
			S_RES: begin
				res_q  <= sat_r[31:0];
				flag_q <= flag_q | sat_r[32];
				g_q    <= {{8{sat_r[31]}}, sat_r[31:0], 24'd0};
			end
			S_FLOAD: begin
				u_q <= uf_rd;
				v_q <= vf_rd;
			end
			U_D: if (tgt_q == TG_U || tgt_q == TG_V) g_q <= p[63:0];
			U_I: flo_q <= fcomb[23:0];
			U_L: ph_q <= p[41:0];
			U_W: flag_q <= flag_q | sat_w[32];
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q.residual  <= res_q;
					out_q.read_data <= rd_q;
					out_q.saturated <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

[rtl/mfsgd_chk.sv]
`timescale 1ns / 1ps

// port-level checks for the SGD engine
module mfsgd_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input mfsgd_pkg::out_t out_item
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted item without going busy");

	// read results carry no residual and no clip flag
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.read_data != 32'sd0)
		|-> (out_item.residual == 32'sd0) && !out_item.saturated)
		else $error("read result mixed with sample result");

	// a new result follows a busy cycle
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without work");

endmodule

bind biased_mf_sgd_update mfsgd_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

	// opcodes the block leaves unused
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 156;

	// idling modes
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	typedef struct {
		mfsgd_pkg::in_t  it;
		bit              fixed;
		mfsgd_pkg::out_t want;
	} vec_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	mfsgd_pkg::in_t   in_item = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	mfsgd_pkg::out_t  out_item;
	logic  cfg_we = 1'b0;
	logic  [2:0] cfg_idx = '0;
	logic  [31:0] cfg_wdata = '0;

	idle_mode_e idle_mode = IDLE_NONE;
	int errs = 0;
	mfsgd_pkg::out_t result_q[$];
	vec_t vecs[$];

	// shadow copy of the block's tables and registers
	logic [23:0] sh_lr = 24'd16777;
	logic [23:0] sh_bd = 24'd167772;
	logic [23:0] sh_fd = 24'd167772;
	logic signed [31:0] sh_gm = '0;
	logic [5:0] sh_af = 6'd32;
	logic signed [31:0] row_bias[4096];
	logic signed [31:0] col_bias[4096];
	logic signed [31:0] row_fac[4096*32];
	logic signed [31:0] col_fac[4096*32];

	int row_pool[8] = '{0, 4095, 'h5A5, 'hA5A, 1, 2, 'h800, 'h7FF};
	int col_pool[8] = '{4095, 0, 'hA5A, 'h5A5, 2, 1, 'h7FF, 'h800};

	biased_mf_sgd_update dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [31:0] clip32(longint x, inout bit flag);
		if (x > 64'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7fffffff;
		end
		if (x < -64'sd2147483648) begin
			flag = 1'b1;
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	// one SGD move of an entry; grad is at scale 2^-48
	function automatic logic signed [31:0] sgd_entry(logic signed [31:0] old, longint grad,
			logic [23:0] decay, inout bit flag);
		longint inner;
		longint delta;
		inner = grad - longint'(decay) * longint'(old);
		delta = (longint'(sh_lr) * (inner >>> 24)) >>> 24;
		return clip32(longint'(old) + delta, flag);
	endfunction

	// expected result of one item; updates the shadow state
	function automatic mfsgd_pkg::out_t mf_predict(mfsgd_pkg::in_t it);
		mfsgd_pkg::out_t o;
		bit flag;
		int nf;
		int r;
		int c;
		longint acc;
		longint g;
		logic signed [31:0] saved[32];
		bit is_row;
		o = '0;
		flag = 1'b0;
		r = it.row_index;
		c = it.col_index;
		nf = (sh_af > mfsgd_pkg::FACTORS) ? 32 : int'(sh_af);
		is_row = (it.opcode == mfsgd_pkg::OP_WR_ROW || it.opcode == mfsgd_pkg::OP_RD_ROW);
		case (it.opcode)
			mfsgd_pkg::OP_WR_ROW, mfsgd_pkg::OP_WR_COL: begin
				if (it.slot == mfsgd_pkg::FACTORS) begin
					if (is_row) row_bias[r] = it.value;
					else col_bias[c] = it.value;
				end else if (it.slot < mfsgd_pkg::FACTORS) begin
					if (is_row) row_fac[r*32 + it.slot] = it.value;
					else col_fac[c*32 + it.slot] = it.value;
				end
			end
			mfsgd_pkg::OP_RD_ROW, mfsgd_pkg::OP_RD_COL: begin
				if (it.slot == mfsgd_pkg::FACTORS)
					o.read_data = is_row ? row_bias[r] : col_bias[c];
				else if (it.slot < mfsgd_pkg::FACTORS)
					o.read_data = is_row ? row_fac[r*32 + it.slot] : col_fac[c*32 + it.slot];
			end
			mfsgd_pkg::OP_TRAIN, mfsgd_pkg::OP_EVAL: begin
				acc = longint'(it.value) - longint'(sh_gm) - longint'(row_bias[r])
					- longint'(col_bias[c]);
				for (int k = 0; k < nf; k++)
					acc -= (longint'(row_fac[r*32+k]) * longint'(col_fac[c*32+k])) >>> 24;
				o.residual = clip32(acc, flag);
				if (it.opcode == mfsgd_pkg::OP_TRAIN) begin
					g = longint'(o.residual) <<< 24;
					row_bias[r] = sgd_entry(row_bias[r], g, sh_bd, flag);
					col_bias[c] = sgd_entry(col_bias[c], g, sh_bd, flag);
					for (int k = 0; k < nf; k++)
						saved[k] = row_fac[r*32+k];
					for (int k = 0; k < nf; k++)
						row_fac[r*32+k] = sgd_entry(saved[k],
							longint'(o.residual) * longint'(col_fac[c*32+k]), sh_fd, flag);
					for (int k = 0; k < nf; k++)
						col_fac[c*32+k] = sgd_entry(col_fac[c*32+k],
							longint'(o.residual) * longint'(saved[k]), sh_fd, flag);
				end
				o.saturated = flag;
			end
			default: ;
		endcase
		return o;
	endfunction

	// present one item, hold it until taken, then log what it should produce
	task automatic send_item(mfsgd_pkg::in_t it, bit fixed, mfsgd_pkg::out_t want);
		mfsgd_pkg::out_t o;
		while ((idle_mode == IDLE_SEND && $urandom_range(99) < 51) ||
				(idle_mode == IDLE_BOTH && $urandom_range(99) < 27)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		o = mf_predict(it);
		result_q.push_back(fixed ? want : o);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			mfsgd_pkg::CFG_LR: sh_lr = data[23:0];
			mfsgd_pkg::CFG_BD: sh_bd = data[23:0];
			mfsgd_pkg::CFG_FD: sh_fd = data[23:0];
			mfsgd_pkg::CFG_GM: sh_gm = data;
			mfsgd_pkg::CFG_AF: sh_af = data[5:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic mfsgd_pkg::in_t mk(logic [2:0] op, int r, int c, int s, logic [31:0] v);
		mfsgd_pkg::in_t it;
		it.opcode = op;
		it.row_index = r[11:0];
		it.col_index = c[11:0];
		it.slot = s[5:0];
		it.value = v;
		return it;
	endfunction

	function automatic vec_t vrow(mfsgd_pkg::in_t it, bit fixed, logic [31:0] rd);
		vec_t v;
		v.it = it;
		v.fixed = fixed;
		v.want = '0;
		v.want.read_data = rd;
		return v;
	endfunction

	// mostly small values near one, sometimes any 32-bit pattern
	function automatic logic [31:0] rand_val();
		if ($urandom_range(9) == 0) return $urandom;
		return $urandom_range(67108864) - 33554432;
	endfunction

	function automatic mfsgd_pkg::in_t rand_item();
		int p;
		logic [2:0] op;
		int s;
		p = $urandom_range(99);
		if (p < 35) op = mfsgd_pkg::OP_TRAIN;
		else if (p < 55) op = mfsgd_pkg::OP_EVAL;
		else if (p < 63) op = mfsgd_pkg::OP_WR_ROW;
		else if (p < 71) op = mfsgd_pkg::OP_WR_COL;
		else if (p < 79) op = mfsgd_pkg::OP_RD_ROW;
		else if (p < 87) op = mfsgd_pkg::OP_RD_COL;
		else if (p < 93) op = OP_SPARE6;
		else op = OP_SPARE7;
		s = ($urandom_range(9) == 0) ? $urandom_range(63, 33) : $urandom_range(32);
		return mk(op, row_pool[$urandom_range(7)], col_pool[$urandom_range(7)], s, rand_val());
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_item);
				errs++;
			end else begin
				mfsgd_pkg::out_t w;
				w = result_q.pop_front();
				if (w.residual !== out_item.residual) begin
					$display("%0t: residual exp %h got %h", $time, w.residual, out_item.residual);
					errs++;
				end
				if (w.read_data !== out_item.read_data) begin
					$display("%0t: read_data exp %h got %h", $time, w.read_data,
						out_item.read_data);
					errs++;
				end
				if (w.saturated !== out_item.saturated) begin
					$display("%0t: saturated exp %b got %b", $time, w.saturated,
						out_item.saturated);
					errs++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (idle_mode == IDLE_RECV) out_stall <= ($urandom_range(99) < 51);
		else if (idle_mode == IDLE_BOTH) out_stall <= ($urandom_range(99) < 27);
		else out_stall <= 1'b0;
	end

	initial begin
		#40000000;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		logic [31:0] cfgs[PHASES][5];
		mfsgd_pkg::out_t zero;
		zero = '0;
		cfgs[0] = '{32'd16777, 32'd167772, 32'd167772, 32'd0, 32'd32};
		cfgs[1] = '{32'hFFFFFF, 32'd0, 32'd0, 32'h7FFFFFFF, 32'd1};
		cfgs[2] = '{32'd0, 32'hFFFFFF, 32'hFFFFFF, 32'h80000000, 32'd0};
		cfgs[3] = '{32'd16777, 32'd167772, 32'd167772, 32'h01000000, 32'd63};
		cfgs[4] = '{$urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
			$urandom_range(67108864) - 33554432, 32'd4};
		cfgs[5] = '{32'h100000, 32'h40000, 32'h40000, -32'sh3000000, 32'd8};
		cfgs[6] = '{32'hFFFFFF, 32'hFFFFFF, 32'd0, 32'd0, 32'd3};
		cfgs[7] = '{$urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF, $urandom & 32'hFFFFFF,
			$urandom_range(67108864) - 33554432, 32'd2};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load every entry the stimulus will touch
		foreach (row_pool[i])
			for (int s = 0; s <= 32; s++) begin
				send_item(mk(mfsgd_pkg::OP_WR_ROW, row_pool[i], 0, s, rand_val()), 1'b1, zero);
				send_item(mk(mfsgd_pkg::OP_WR_COL, 0, col_pool[i], s, rand_val()), 1'b1, zero);
			end

		// directed: extremes, ignored slots, spare opcodes, then sample items
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_ROW, 0, 0, 0, 32'h7FFFFFFF), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_ROW, 0, 4095, 0, 32'hFFFFFFFF), 1, 32'h7FFFFFFF));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_COL, 4095, 4095, 31, 32'h80000000), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_COL, 0, 4095, 31, 0), 1, 32'h80000000));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_ROW, 4095, 0, 32, 32'h80000000), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_ROW, 4095, 0, 32, 0), 1, 32'h80000000));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_COL, 0, 0, 32, 32'h7FFFFFFF), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_COL, 4095, 0, 32, 0), 1, 32'h7FFFFFFF));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_ROW, 0, 0, 63, 32'h12345678), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_ROW, 0, 0, 63, 0), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_COL, 0, 0, 33, 0), 1, 0));
		vecs.push_back(vrow(mk(OP_SPARE6, 4095, 4095, 63, 32'hFFFFFFFF), 1, 0));
		vecs.push_back(vrow(mk(OP_SPARE7, 4095, 4095, 32, 32'h7FFFFFFF), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_EVAL, 0, 4095, 0, 32'h7FFFFFFF), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_TRAIN, 0, 4095, 0, 32'h80000000), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_ROW, 0, 0, 0, 0), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_EVAL, 1, 2, 0, 32'h80000000), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_TRAIN, 1, 2, 0, 32'h01000000), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_TRAIN, 4095, 0, 0, 32'h7FFFFFFF), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_RD_COL, 0, 2, 5, 0), 0, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_ROW, 0, 0, 0, 32'h01000000), 1, 0));
		vecs.push_back(vrow(mk(mfsgd_pkg::OP_WR_COL, 0, 4095, 31, 32'hFF000000), 1, 0));
		foreach (vecs[i])
			send_item(vecs[i].it, vecs[i].fixed, vecs[i].want);
		drain();

		// random phases, each with its own settings and idling
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph != 0) begin
				write_reg(mfsgd_pkg::CFG_LR, cfgs[ph][0]);
				write_reg(mfsgd_pkg::CFG_BD, cfgs[ph][1]);
				write_reg(mfsgd_pkg::CFG_FD, cfgs[ph][2]);
				write_reg(mfsgd_pkg::CFG_GM, cfgs[ph][3]);
				write_reg(mfsgd_pkg::CFG_AF, cfgs[ph][4]);
				cfg_we <= 1'b0;
				@(posedge clk);
			end
			idle_mode = idle_mode_e'(ph % 4);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_item(), 1'b0, zero);
			drain();
			idle_mode = IDLE_NONE;
		end

		repeat (20) @(posedge clk);
		if (errs == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
